>>> hw/rtl/gncs_pkg.sv
package gncs_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_NUM_COLORS = 32;
  localparam int DEF_ENTRY_BITS = 16;

  localparam int HEIGHT_LIMIT = 64;
  localparam int ROW_W        = 6;
  localparam int HGT_W        = 7;
  localparam int WID_CMP_W    = 11;
  localparam int REG_W        = 7;
  localparam int LABEL_W      = 5;
  localparam int LABEL_CODES  = 32;
  localparam int SCORE_W      = 32;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [REG_W-1:0] GRID_WIDTH_RST  = 7'd8;
  localparam logic [REG_W-1:0] GRID_HEIGHT_RST = 7'd8;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_CELL  = 1'b1;

  localparam int RD_CC  = 0;
  localparam int RD_C0  = 1;
  localparam int RD_CL  = 2;
  localparam int RD_LC  = 3;
  localparam int RD_CUL = 4;
  localparam int RD_ULC = 5;
  localparam int RD_CU  = 6;
  localparam int RD_UC  = 7;
  localparam int RD_CUR = 8;
  localparam int RD_URC = 9;
  localparam int NUM_RD = 10;

  typedef struct packed {
    logic             left_in;
    logic             ul_in;
    logic             up_in;
    logic             ur_in;
    logic [3:0]       out_cnt;
    logic             last;
  } nbr_flags_t;

  typedef struct packed {
    logic [WID_CMP_W-1:0] eff_w;
    logic [HGT_W-1:0]     eff_h;
    logic                 restart;
  } cfg_ctrl_t;

endpackage

>>> hw/rtl/gncs_cfg.sv
module gncs_cfg import gncs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_ctrl_t         ctrl
);

  logic [REG_W-1:0] width_r;
  logic [REG_W-1:0] height_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GRID_WIDTH_RST;
      height_r <= GRID_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  width_r  <= pwdata[REG_W-1:0];
        REG_GRID_HEIGHT: height_r <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = DATA_W'(width_r);
      REG_GRID_HEIGHT: prdata = DATA_W'(height_r);
    endcase
  end

  always_comb begin
    ctrl.restart = wr_en;
    if (width_r == '0) begin
      ctrl.eff_w = WID_CMP_W'(1);
    end else if (WID_CMP_W'(width_r) > WID_CMP_W'(MAX_WIDTH)) begin
      ctrl.eff_w = WID_CMP_W'(MAX_WIDTH);
    end else begin
      ctrl.eff_w = WID_CMP_W'(width_r);
    end
    if (height_r == '0) begin
      ctrl.eff_h = HGT_W'(1);
    end else if (height_r > HGT_W'(HEIGHT_LIMIT)) begin
      ctrl.eff_h = HGT_W'(HEIGHT_LIMIT);
    end else begin
      ctrl.eff_h = height_r;
    end
  end

endmodule

>>> hw/rtl/gncs_table.sv
module gncs_table import gncs_pkg::*; #(
  parameter int NUM_COLORS = DEF_NUM_COLORS,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS,
  parameter int DEPTH      = NUM_COLORS * NUM_COLORS,
  parameter int TBL_AW     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [TBL_AW-1:0]     waddr,
  input  logic [ENTRY_BITS-1:0] wdata,
  input  logic                  rd_en,
  input  logic [TBL_AW-1:0]     raddr [NUM_RD],
  output logic [ENTRY_BITS-1:0] rdata [NUM_RD]
);

  // one copy per read port, all written together
  for (genvar g = 0; g < NUM_RD; g++) begin : g_copy
    logic [ENTRY_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (rd_en) begin
        rdata[g] <= mem[raddr[g]];
      end
    end
  end

endmodule

>>> hw/rtl/gncs_row_buf.sv
module gncs_row_buf import gncs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [COL_W-1:0]   waddr,
  input  logic [LABEL_W-1:0] wdata,
  input  logic [COL_W-1:0]   raddr0,
  input  logic [COL_W-1:0]   raddr1,
  output logic [LABEL_W-1:0] rdata0,
  output logic [LABEL_W-1:0] rdata1
);

  logic [LABEL_W-1:0] mem [MAX_WIDTH];

  // write-first on a same-address read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
    rdata1 <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
  end

endmodule

>>> hw/rtl/gncs_cell_sum.sv
module gncs_cell_sum import gncs_pkg::*; #(
  parameter int ENTRY_BITS = DEF_ENTRY_BITS,
  parameter int SUM_W      = ENTRY_BITS + 5
) (
  input  nbr_flags_t            flags,
  input  logic [ENTRY_BITS-1:0] rd [NUM_RD],
  output logic [SUM_W-1:0]      cell_sum
);

  logic [SUM_W-1:0] edge_part;
  logic [SUM_W-1:0] pair_l;
  logic [SUM_W-1:0] pair_ul;
  logic [SUM_W-1:0] pair_u;
  logic [SUM_W-1:0] pair_ur;

  always_comb begin
    edge_part = SUM_W'(rd[RD_C0]) * SUM_W'(flags.out_cnt);
    pair_l    = flags.left_in ? SUM_W'(rd[RD_CL]) + SUM_W'(rd[RD_LC]) : '0;
    pair_ul   = flags.ul_in ? SUM_W'(rd[RD_CUL]) + SUM_W'(rd[RD_ULC]) : '0;
    pair_u    = flags.up_in ? SUM_W'(rd[RD_CU]) + SUM_W'(rd[RD_UC]) : '0;
    pair_ur   = flags.ur_in ? SUM_W'(rd[RD_CUR]) + SUM_W'(rd[RD_URC]) : '0;
    cell_sum  = SUM_W'(rd[RD_CC]) + edge_part + pair_l + pair_ul + pair_u + pair_ur;
  end

endmodule

>>> hw/rtl/grid_neighbor_contrast_score.sv
// a grid's score word is valid once its last cell has passed stages a, b and c
// throughput: one item (cell or table write) per cycle while in_stall is low, set by
//   the table read stage and the accumulate adder; out_stall can back up to in_stall
// reset: synchronous, active low; clears counters, edge labels, score and valids
// the contrast table and row buffer are not cleared and hold nothing until written
module grid_neighbor_contrast_score import gncs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int NUM_COLORS = DEF_NUM_COLORS,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [LABEL_W-1:0] in_row_label,
  input  logic [LABEL_W-1:0] in_col_label,
  input  logic [15:0]        in_entry_value,
  input  logic [LABEL_W-1:0] in_cell_label,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] out_total_score
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LBL_W  = $clog2(NUM_COLORS);
  localparam int DEPTH  = NUM_COLORS * NUM_COLORS;
  localparam int TBL_AW = $clog2(DEPTH);
  localparam int SUM_W  = ENTRY_BITS + 5;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LBL_W-1:0] r,
                                                 input logic [LBL_W-1:0] k);
    tbl_addr = TBL_AW'(TBL_AW'(r) * TBL_AW'(NUM_COLORS) + TBL_AW'(k));
  endfunction

  cfg_ctrl_t ctrl;

  gncs_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  // label reduction table
  logic [LBL_W-1:0] lbl_map [LABEL_CODES];
  for (genvar i = 0; i < LABEL_CODES; i++) begin : g_lbl
    assign lbl_map[i] = LBL_W'(i % NUM_COLORS);
  end

  logic             in_acc;
  logic             cell_acc;
  logic             tbl_we;
  logic             a_ready;
  logic             b_ready;
  logic             c_ready;
  logic             c_go;
  logic             out_free;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [LBL_W-1:0] left_r, left_nxt;
  logic [LBL_W-1:0] ul_r, ul_nxt;
  logic [COL_W-1:0] ur_raddr;
  logic [LABEL_W-1:0] up_rd;
  logic [LABEL_W-1:0] ur_rd;
  logic [LBL_W-1:0] cell_c;
  nbr_flags_t       flags_nxt;

  logic             a_valid_r;
  logic [LBL_W-1:0] a_c_r;
  logic [LBL_W-1:0] a_l_r;
  logic [LBL_W-1:0] a_ul_r;
  logic [LBL_W-1:0] a_u_r;
  logic [LBL_W-1:0] a_ur_r;
  nbr_flags_t       a_flags_r;

  logic             b_valid_r;
  nbr_flags_t       b_flags_r;
  logic             b_load;

  logic             c_valid_r;
  logic             c_last_r;
  logic [SUM_W-1:0] c_sum_r;
  logic [SUM_W-1:0] cell_sum;

  logic [SCORE_W-1:0] score_r;
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;

  logic [TBL_AW-1:0]     rd_addr [NUM_RD];
  logic [ENTRY_BITS-1:0] rd_data [NUM_RD];

  // pipeline handshake
  assign out_free = !out_valid_r || !out_stall;
  assign c_go     = c_valid_r && (!c_last_r || out_free);
  assign c_ready  = !c_valid_r || c_go;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign b_load   = a_valid_r && b_ready;
  assign in_stall = !a_ready;
  assign in_acc   = in_valid && !in_stall;
  assign cell_acc = in_acc && (in_op == OP_CELL);
  assign tbl_we   = in_acc && (in_op == OP_TABLE);
  assign cell_c   = lbl_map[in_cell_label];

  // position, neighbor flags and counter update
  always_comb begin
    logic       l_in;
    logic       r_in;
    logic       u_in;
    logic       d_in;
    logic [7:0] nb;
    l_in = (col_r != '0);
    r_in = (WID_CMP_W'(col_r) + WID_CMP_W'(1)) < ctrl.eff_w;
    u_in = (row_r != '0);
    d_in = (HGT_W'(row_r) + HGT_W'(1)) < ctrl.eff_h;
    nb   = {u_in && l_in, u_in, u_in && r_in, l_in, r_in,
            d_in && l_in, d_in, d_in && r_in};
    flags_nxt.left_in = l_in;
    flags_nxt.ul_in   = u_in && l_in;
    flags_nxt.up_in   = u_in;
    flags_nxt.ur_in   = u_in && r_in;
    flags_nxt.out_cnt = 4'd8 - 4'($countones(nb));
    flags_nxt.last    = !r_in && !d_in;

    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    ul_nxt   = ul_r;
    if (ctrl.restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = '0;
      ul_nxt   = '0;
    end else if (cell_acc) begin
      if (r_in) begin
        col_nxt  = COL_W'(col_r + COL_W'(1));
        left_nxt = cell_c;
        ul_nxt   = lbl_map[up_rd];
      end else begin
        col_nxt  = '0;
        left_nxt = '0;
        ul_nxt   = '0;
        row_nxt  = d_in ? ROW_W'(row_r + ROW_W'(1)) : '0;
      end
    end

    if ((WID_CMP_W'(col_nxt) + WID_CMP_W'(1)) == WID_CMP_W'(MAX_WIDTH)) begin
      ur_raddr = '0;
    end else begin
      ur_raddr = COL_W'(col_nxt + COL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      ul_r   <= ul_nxt;
    end
  end

  gncs_row_buf #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_row_buf (
    .clk    (clk),
    .we     (cell_acc),
    .waddr  (col_r),
    .wdata  (LABEL_W'(cell_c)),
    .raddr0 (col_nxt),
    .raddr1 (ur_raddr),
    .rdata0 (up_rd),
    .rdata1 (ur_rd)
  );

  // stage a: accepted cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= cell_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      a_c_r     <= cell_c;
      a_l_r     <= left_r;
      a_ul_r    <= ul_r;
      a_u_r     <= lbl_map[up_rd];
      a_ur_r    <= lbl_map[ur_rd];
      a_flags_r <= flags_nxt;
    end
  end

  always_comb begin
    rd_addr[RD_CC]  = tbl_addr(a_c_r, a_c_r);
    rd_addr[RD_C0]  = tbl_addr(a_c_r, '0);
    rd_addr[RD_CL]  = tbl_addr(a_c_r, a_l_r);
    rd_addr[RD_LC]  = tbl_addr(a_l_r, a_c_r);
    rd_addr[RD_CUL] = tbl_addr(a_c_r, a_ul_r);
    rd_addr[RD_ULC] = tbl_addr(a_ul_r, a_c_r);
    rd_addr[RD_CU]  = tbl_addr(a_c_r, a_u_r);
    rd_addr[RD_UC]  = tbl_addr(a_u_r, a_c_r);
    rd_addr[RD_CUR] = tbl_addr(a_c_r, a_ur_r);
    rd_addr[RD_URC] = tbl_addr(a_ur_r, a_c_r);
  end

  gncs_table #(
    .NUM_COLORS (NUM_COLORS),
    .ENTRY_BITS (ENTRY_BITS),
    .DEPTH      (DEPTH),
    .TBL_AW     (TBL_AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr(lbl_map[in_row_label], lbl_map[in_col_label])),
    .wdata (ENTRY_BITS'(in_entry_value)),
    .rd_en (b_load),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // stage b: table words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_flags_r <= a_flags_r;
    end
  end

  gncs_cell_sum #(.ENTRY_BITS(ENTRY_BITS), .SUM_W(SUM_W)) u_cell_sum (
    .flags    (b_flags_r),
    .rd       (rd_data),
    .cell_sum (cell_sum)
  );

  // stage c: cell sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && c_ready) begin
      c_sum_r  <= cell_sum;
      c_last_r <= b_flags_r.last;
    end
  end

  // accumulate and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.restart) begin
        score_r <= '0;
      end else if (c_go) begin
        score_r <= c_last_r ? '0 : score_r + SCORE_W'(c_sum_r);
      end
      if (c_go && c_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_go && c_last_r) begin
      out_score_r <= score_r + SCORE_W'(c_sum_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total_score = out_score_r;

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    WID_CMP_W'(col_r) < ctrl.eff_w)
    else $error("column counter outside grid");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && b_valid_r && c_valid_r && c_last_r && out_valid_r))
    else $error("input stalled without a blocked result");

  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_last_r && !out_free) |=> (c_valid_r && c_last_r && $stable(c_sum_r)))
    else $error("blocked last cell lost");

endmodule
